>>> hdl/tnc_pkg.sv
// Shared constants, codes and the result record of the tag nesting checker.
`default_nettype none

package tnc_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int NAME_MAX_DEF    = 29;

	localparam int DEPTH_W = 5;
	localparam int DATA_W  = 8;
	localparam int LEN_W   = 5;

	localparam logic [DATA_W-1:0] CH_LT    = 8'h3C;
	localparam logic [DATA_W-1:0] CH_GT    = 8'h3E;
	localparam logic [DATA_W-1:0] CH_SLASH = 8'h2F;

	// Result queue geometry.
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = 2;
	localparam int OUTQ_CNT_W = 3;

	typedef enum logic [2:0] {
		EV_TEXT  = 3'd0,
		EV_OPEN  = 3'd1,
		EV_CLOSE = 3'd2,
		EV_ERROR = 3'd3,
		EV_END   = 3'd4
	} event_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE          = 3'd0,
		ERR_CLOSE_NO_OPEN = 3'd1,
		ERR_MISMATCH      = 3'd2,
		ERR_NAME_LONG     = 3'd3,
		ERR_STACK_FULL    = 3'd4,
		ERR_UNTERMINATED  = 3'd5,
		ERR_UNCLOSED      = 3'd6
	} err_code_t;

	typedef struct packed {
		event_kind_t         kind;
		logic [DEPTH_W-1:0]  depth;
		logic [DATA_W-1:0]   data;
		logic [LEN_W-1:0]    len;
		logic                run;
		err_code_t           code;
		logic                eod;
	} result_t;

	function automatic result_t mk_result(input event_kind_t kind,
			input logic [DEPTH_W-1:0] depth, input logic [DATA_W-1:0] data,
			input logic [LEN_W-1:0] len, input logic run, input err_code_t code,
			input logic eod);
		result_t r;
		r.kind  = kind;
		r.depth = depth;
		r.data  = data;
		r.len   = len;
		r.run   = run;
		r.code  = code;
		r.eod   = eod;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/tnc_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none

module tnc_ram
	import tnc_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/tnc_out_fifo.sv
// Small result queue that takes up to two results per cycle and hands out one.
`default_nettype none

module tnc_out_fifo
	import tnc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push0,
	input  wire logic    push1,
	input  wire result_t res0,
	input  wire result_t res1,
	output logic         has_room,
	output logic         head_valid,
	output result_t      head,
	input  wire logic    head_ready
);

	result_t                slot_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0]  wp_q;
	logic [OUTQ_PTR_W-1:0]  rp_q;
	logic [OUTQ_CNT_W-1:0]  cnt_q;
	logic                   pop;

	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rp_q];
	assign pop        = head_valid & head_ready;
	// Room for the worst case of two results from the next item.
	assign has_room   = (cnt_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push0) begin
			slot_q[wp_q] <= res0;
		end
		if (push1) begin
			slot_q[wp_q + OUTQ_PTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OUTQ_PTR_W'(push0) + OUTQ_PTR_W'(push1);
			rp_q  <= rp_q + OUTQ_PTR_W'(pop);
			cnt_q <= cnt_q + OUTQ_CNT_W'(push0) + OUTQ_CNT_W'(push1)
				- OUTQ_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

>>> hdl/tnc_parser.sv
// Tag parser: mode tracking, stack pointer, name compare and result forming.
`default_nettype none

module tnc_parser
	import tnc_pkg::*;
#(
	parameter int SD    = STACK_DEPTH_DEF,
	parameter int NM    = NAME_MAX_DEF,
	parameter int IDX_W = $clog2(NM + 1),
	parameter int SA_W  = (SD * NM > 1) ? $clog2(SD * NM) : 1,
	parameter int LA_W  = (SD > 1) ? $clog2(SD) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [DATA_W-1:0] data_byte,
	input  wire logic              last_byte,
	output result_t                res0,
	output result_t                res1,
	output logic                   push0,
	output logic                   push1,
	output logic                   store_we,
	output logic      [SA_W-1:0]   store_waddr,
	output logic      [DATA_W-1:0] store_wdata,
	output logic                   store_re,
	output logic      [SA_W-1:0]   store_raddr,
	input  wire logic [DATA_W-1:0] store_rdata,
	output logic                   len_we,
	output logic      [LA_W-1:0]   len_waddr,
	output logic      [IDX_W-1:0]  len_wdata,
	output logic                   len_re,
	output logic      [LA_W-1:0]   len_raddr,
	input  wire logic [IDX_W-1:0]  len_rdata
);

	localparam int TOP_W  = $clog2(SD + 1);
	localparam int BASE_W = $clog2(SD * NM + 1);

	typedef enum logic [3:0] {
		MODE_TEXT  = 4'b0001,
		MODE_LT    = 4'b0010,
		MODE_OPEN  = 4'b0100,
		MODE_CLOSE = 4'b1000
	} mode_t;

	mode_t              mode_q, mode_d;
	logic [TOP_W-1:0]   top_q, top_d;
	logic [BASE_W-1:0]  base_q, base_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic               mism_q, mism_d;
	logic               err_q, err_d;
	err_code_t          code_q, code_d;
	logic               run_q, run_d;
	logic [IDX_W-1:0]   top_len_q;
	logic               len_pend_q;

	logic               tk_v;
	result_t            tk_r;
	logic               e5_v;
	result_t            e5_r;
	result_t            end_r;
	logic               do_fail;
	err_code_t          fcode;
	logic               push_tag;
	logic [BASE_W-1:0]  base_m;
	logic [IDX_W-1:0]   idx_inc;
	logic               in_open;
	err_code_t          end_code;

	assign base_m  = base_q - BASE_W'(NM);
	assign idx_inc = idx_q + IDX_W'(1);
	assign in_open = (mode_q == MODE_OPEN) ||
		((mode_q == MODE_LT) && (data_byte != CH_SLASH));

	always_comb begin
		mode_d      = mode_q;
		top_d       = top_q;
		base_d      = base_q;
		idx_d       = idx_q;
		mism_d      = mism_q;
		err_d       = err_q;
		code_d      = code_q;
		run_d       = run_q;
		tk_v        = 1'b0;
		tk_r        = mk_result(EV_TEXT, '0, '0, '0, 1'b0, ERR_NONE, 1'b0);
		do_fail     = 1'b0;
		fcode       = ERR_NONE;
		push_tag    = 1'b0;
		store_we    = 1'b0;
		store_waddr = SA_W'(base_q + BASE_W'(idx_q));
		store_wdata = data_byte;
		store_re    = 1'b0;
		store_raddr = SA_W'(base_m);
		len_we      = 1'b0;
		len_waddr   = LA_W'(top_q);
		len_wdata   = idx_q;
		len_re      = 1'b0;
		len_raddr   = LA_W'(top_q - TOP_W'(2));

		if (!err_q) begin
			if (mode_q == MODE_TEXT) begin
				if (data_byte == CH_LT) begin
					mode_d = MODE_LT;
					run_d  = 1'b0;
					idx_d  = '0;
					mism_d = 1'b0;
				end else begin
					tk_v  = 1'b1;
					tk_r  = mk_result(EV_TEXT, DEPTH_W'(top_q), data_byte, '0,
						!run_q, ERR_NONE, 1'b0);
					run_d = 1'b1;
				end
			end else if (mode_q == MODE_LT && data_byte == CH_SLASH) begin
				mode_d = MODE_CLOSE;
				// Fetch the first byte of the top name ahead of its compare.
				store_re    = (top_q != '0);
				store_raddr = SA_W'(base_m);
			end else if (in_open) begin
				mode_d = MODE_OPEN;
				if (data_byte == CH_GT) begin
					if (top_q >= TOP_W'(SD)) begin
						do_fail = 1'b1;
						fcode   = ERR_STACK_FULL;
					end else begin
						len_we   = 1'b1;
						push_tag = 1'b1;
						top_d    = top_q + TOP_W'(1);
						base_d   = base_q + BASE_W'(NM);
						mode_d   = MODE_TEXT;
						tk_v     = 1'b1;
						tk_r     = mk_result(EV_OPEN, DEPTH_W'(top_q + TOP_W'(1)), '0,
							LEN_W'(idx_q), 1'b0, ERR_NONE, 1'b0);
					end
				end else if (idx_q >= IDX_W'(NM)) begin
					do_fail = 1'b1;
					fcode   = ERR_NAME_LONG;
				end else begin
					store_we = (top_q < TOP_W'(SD));
					idx_d    = idx_inc;
				end
			end else begin
				if (data_byte == CH_GT) begin
					if (top_q == '0) begin
						do_fail = 1'b1;
						fcode   = ERR_CLOSE_NO_OPEN;
					end else if (mism_q || (idx_q != top_len_q)) begin
						do_fail = 1'b1;
						fcode   = ERR_MISMATCH;
					end else begin
						top_d  = top_q - TOP_W'(1);
						base_d = base_m;
						mode_d = MODE_TEXT;
						// The new top's length comes back from the length RAM.
						len_re = (top_q > TOP_W'(1));
						tk_v   = 1'b1;
						tk_r   = mk_result(EV_CLOSE, DEPTH_W'(top_q - TOP_W'(1)), '0,
							LEN_W'(idx_q), 1'b0, ERR_NONE, 1'b0);
					end
				end else if (idx_q >= IDX_W'(NM)) begin
					do_fail = 1'b1;
					fcode   = ERR_NAME_LONG;
				end else begin
					if ((top_q == '0) || (idx_q >= top_len_q) ||
							(store_rdata != data_byte)) begin
						mism_d = 1'b1;
					end
					idx_d       = idx_inc;
					store_re    = (top_q != '0) && (idx_inc < top_len_q);
					store_raddr = SA_W'(base_m + BASE_W'(idx_inc));
				end
			end
		end

		if (do_fail) begin
			err_d  = 1'b1;
			code_d = fcode;
			mode_d = MODE_TEXT;
			tk_v   = 1'b1;
			tk_r   = mk_result(EV_ERROR, DEPTH_W'(top_q), '0, '0, 1'b0, fcode, 1'b0);
		end

		e5_v     = last_byte && !err_d && (mode_d != MODE_TEXT);
		e5_r     = mk_result(EV_ERROR, DEPTH_W'(top_d), '0, '0, 1'b0,
			ERR_UNTERMINATED, 1'b0);
		end_code = e5_v ? ERR_UNTERMINATED :
			(err_d ? code_d : ((top_d != '0) ? ERR_UNCLOSED : ERR_NONE));
		end_r    = mk_result(EV_END, DEPTH_W'(top_d), '0, '0, 1'b0, end_code, 1'b1);

		if (last_byte) begin
			mode_d = MODE_TEXT;
			top_d  = '0;
			base_d = '0;
			idx_d  = '0;
			mism_d = 1'b0;
			err_d  = 1'b0;
			code_d = ERR_NONE;
			run_d  = 1'b0;
		end

		store_we = store_we & accept;
		store_re = store_re & accept;
		len_we   = len_we & accept;
		len_re   = len_re & accept;
	end

	// Results are packed so that the first valid one always sits in slot zero.
	assign res0  = tk_v ? tk_r : (e5_v ? e5_r : end_r);
	assign res1  = end_r;
	assign push0 = accept & (tk_v | last_byte);
	assign push1 = accept & last_byte & (tk_v | e5_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_TEXT;
			top_q      <= '0;
			base_q     <= '0;
			idx_q      <= '0;
			mism_q     <= 1'b0;
			err_q      <= 1'b0;
			code_q     <= ERR_NONE;
			run_q      <= 1'b0;
			len_pend_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q <= mode_d;
				top_q  <= top_d;
				base_q <= base_d;
				idx_q  <= idx_d;
				mism_q <= mism_d;
				err_q  <= err_d;
				code_q <= code_d;
				run_q  <= run_d;
			end
			len_pend_q <= len_re;
		end
	end

	// Length of the name on top of the stack, for the close compare.
	always_ff @(posedge clk) begin
		if (accept && push_tag) begin
			top_len_q <= idx_q;
		end else if (len_pend_q) begin
			top_len_q <= len_rdata;
		end
	end

endmodule

`default_nettype wire

>>> hdl/tag_nesting_checker.sv
// Top level of the tag nesting checker: parser, name and length RAMs, result queue.
//
//  Channel | Handshake                   | Payload
//  --------+-----------------------------+------------------------------------------------
//  input   | data_valid / data_ready     | data_byte, last_byte
//  output  | event_valid / event_ready   | event_kind, nest_depth, out_byte, name_length,
//          |                             | run_start, error_code, end_of_document
//
// The block takes one byte per cycle while data_ready is high. Each byte is
// parsed in the cycle it is accepted, and its zero, one or two results are
// written into a four-entry result queue, so the first result appears in the
// cycle after the byte. The input is ready while the queue can take two more
// results; a stalled output therefore stops input once the queue holds three.
// Reset clears the parser state and the queue at once; the name and length
// RAMs are not cleared, since only entries written by an open tag are read.
`default_nettype none

module tag_nesting_checker
	import tnc_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int NAME_MAX    = NAME_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              data_valid,
	output logic                   data_ready,
	input  wire logic [DATA_W-1:0] data_byte,
	input  wire logic              last_byte,
	output logic                   event_valid,
	input  wire logic              event_ready,
	output logic [2:0]             event_kind,
	output logic [DEPTH_W-1:0]     nest_depth,
	output logic [DATA_W-1:0]      out_byte,
	output logic [LEN_W-1:0]       name_length,
	output logic                   run_start,
	output logic [2:0]             error_code,
	output logic                   end_of_document
);

	// Name bytes live in one RAM with a slot of NAME_MAX bytes per stack level;
	// name lengths live in a second RAM with one entry per level.
	localparam int IDX_W       = $clog2(NAME_MAX + 1);
	localparam int STORE_DEPTH = STACK_DEPTH * NAME_MAX;
	localparam int SA_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int LA_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic              accept;
	result_t           res0;
	result_t           res1;
	logic              push0;
	logic              push1;
	result_t           head;

	logic              store_we;
	logic [SA_W-1:0]   store_waddr;
	logic [DATA_W-1:0] store_wdata;
	logic              store_re;
	logic [SA_W-1:0]   store_raddr;
	logic [DATA_W-1:0] store_rdata;

	logic              len_we;
	logic [LA_W-1:0]   len_waddr;
	logic [IDX_W-1:0]  len_wdata;
	logic              len_re;
	logic [LA_W-1:0]   len_raddr;
	logic [IDX_W-1:0]  len_rdata;

	assign accept = data_valid & data_ready;

	// The parser reads the next name byte of the top tag one item ahead, so the
	// compare for a close-name byte uses data already held at the RAM output.
	// Writes happen only inside an open name and reads only inside a close name,
	// so one entry is never written and read in the same cycle.
	tnc_parser #(
		.SD    (STACK_DEPTH),
		.NM    (NAME_MAX),
		.IDX_W (IDX_W),
		.SA_W  (SA_W),
		.LA_W  (LA_W)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.res0        (res0),
		.res1        (res1),
		.push0       (push0),
		.push1       (push1),
		.store_we    (store_we),
		.store_waddr (store_waddr),
		.store_wdata (store_wdata),
		.store_re    (store_re),
		.store_raddr (store_raddr),
		.store_rdata (store_rdata),
		.len_we      (len_we),
		.len_waddr   (len_waddr),
		.len_wdata   (len_wdata),
		.len_re      (len_re),
		.len_raddr   (len_raddr),
		.len_rdata   (len_rdata)
	);

	tnc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_DEPTH),
		.AW    (SA_W)
	) u_name_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (store_wdata),
		.re    (store_re),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	// After a close the length of the new top is read back here; the next close
	// compare is at least two items later, so the value is always in place.
	tnc_ram #(
		.WIDTH (IDX_W),
		.DEPTH (STACK_DEPTH),
		.AW    (LA_W)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.re    (len_re),
		.raddr (len_raddr),
		.rdata (len_rdata)
	);

	tnc_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push0      (push0),
		.push1      (push1),
		.res0       (res0),
		.res1       (res1),
		.has_room   (data_ready),
		.head_valid (event_valid),
		.head       (head),
		.head_ready (event_ready)
	);

	assign event_kind      = head.kind;
	assign nest_depth      = head.depth;
	assign out_byte        = head.data;
	assign name_length     = head.len;
	assign run_start       = head.run;
	assign error_code      = head.code;
	assign end_of_document = head.eod;

endmodule

`default_nettype wire
